/* sv/skl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package skl_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // how the result registers are loaded at the end of a transaction
  typedef enum logic [1:0] {
    FIN_ZERO,
    FIN_OVF,
    FIN_CHECK
  } fin_kind_t;

  typedef struct packed {
    logic      capture;
    logic      srch_init;
    logic      srch_step;
    logic      past_equal;
    logic      rd_mid;
    logic      rd_lo;
    logic      rd_shift;
    logic      wr_shift;
    logic      wr_new;
    logic      idx_dec;
    logic      count_clr;
    logic      finish;
    fin_kind_t fin_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic search_done;
    logic shift_done;
    logic lo_valid;
  } dp_stat_t;

endpackage

`default_nettype wire

/* sv/sorted_key_table_lookup.sv */
`timescale 1ns / 1ps
`default_nettype none

// sorted (key, value) table with insert, exact-match lookup and clear
// - a transaction is taken at a rising edge with start high and busy low;
//   cmd selects load (insert in key order), lookup or clear
// - every transaction gives exactly one result: done is high for one cycle
//   with found, result_value and overflow valid in that cycle; the receiver
//   cannot stall, so results are never held back
// - clear, a load into a full table and an unused command finish from idle
// - lookup: a binary search over the key memory, each halving step a memory
//   read then a compare; if the bound is a stored entry, a final read and
//   match follows, else a miss is reported
// - load: the same search, then entries above the insert point move up one
//   place, each by a read and a write through the single read and write
//   port, then the new entry is written at the insert point
// - busy is high from the cycle after a lookup or a load into a non-full
//   table is taken until its result shows; the others never raise busy
// - reset empties the table and returns the controller to idle; no clearing
//   pass is needed since only stored entries are ever read
module sorted_key_table_lookup #(
  parameter int TABLE_DEPTH = skl_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [skl_pkg::CMD_W-1:0] cmd,
  input  wire logic [skl_pkg::KEY_W-1:0] key,
  input  wire logic [skl_pkg::VAL_W-1:0] value,
  output logic                           done,
  output logic                           found,
  output logic [skl_pkg::VAL_W-1:0]      result_value,
  output logic                           overflow
);

  skl_pkg::dp_cmd_t  dp_cmd;
  skl_pkg::dp_stat_t dp_stat;

  skl_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .dp_stat (dp_stat),
    .dp_cmd  (dp_cmd),
    .busy    (busy),
    .done    (done)
  );

  skl_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .key          (key),
    .value        (value),
    .dp_cmd       (dp_cmd),
    .dp_stat      (dp_stat),
    .found        (found),
    .result_value (result_value),
    .overflow     (overflow)
  );

endmodule

`default_nettype wire

/* sv/skl_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module skl_datapath #(
  parameter int TABLE_DEPTH = skl_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [skl_pkg::KEY_W-1:0] key,
  input  wire logic [skl_pkg::VAL_W-1:0] value,
  input  wire skl_pkg::dp_cmd_t         dp_cmd,
  output skl_pkg::dp_stat_t             dp_stat,
  output logic                          found,
  output logic [skl_pkg::VAL_W-1:0]     result_value,
  output logic                          overflow
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = skl_pkg::KEY_W + skl_pkg::VAL_W;

  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rdata;

  logic [skl_pkg::KEY_W-1:0] key_q;
  logic [skl_pkg::VAL_W-1:0] value_q;
  logic [CW-1:0]             count;
  logic [CW-1:0]             lo;
  logic [CW-1:0]             hi;
  logic [CW-1:0]             idx;

  logic [CW-1:0]             mid;
  logic [CW-1:0]             idx_m1;
  logic [skl_pkg::KEY_W-1:0] rd_key;
  logic [skl_pkg::VAL_W-1:0] rd_val;
  logic                      go_right;
  logic                      key_hit;
  logic                      mem_re;
  logic                      mem_we;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             wr_addr;
  logic [EW-1:0]             wr_data;

  assign mid    = lo + ((hi - lo) >> 1);
  assign idx_m1 = idx - CW'(1);
  assign rd_key = rdata[EW-1:skl_pkg::VAL_W];
  assign rd_val = rdata[skl_pkg::VAL_W-1:0];

  // lower bound for lookups, upper bound for inserts
  assign go_right = dp_cmd.past_equal ? (rd_key <= key_q) : (rd_key < key_q);
  assign key_hit  = (rd_key == key_q);

  assign mem_re  = dp_cmd.rd_mid | dp_cmd.rd_lo | dp_cmd.rd_shift;
  assign mem_we  = dp_cmd.wr_new | dp_cmd.wr_shift;

  always_comb begin
    priority if (dp_cmd.rd_mid) begin
      rd_addr = mid[AW-1:0];
    end else if (dp_cmd.rd_lo) begin
      rd_addr = lo[AW-1:0];
    end else begin
      rd_addr = idx_m1[AW-1:0];
    end
  end

  assign wr_addr = dp_cmd.wr_new ? lo[AW-1:0] : idx[AW-1:0];
  assign wr_data = dp_cmd.wr_new ? {key_q, value_q} : rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (dp_cmd.count_clr) begin
      count <= '0;
    end else if (dp_cmd.wr_new) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      key_q   <= key;
      value_q <= value;
    end
    if (dp_cmd.srch_init) begin
      lo  <= '0;
      hi  <= count;
      idx <= count;
    end else begin
      if (dp_cmd.srch_step) begin
        if (go_right) begin
          lo <= mid + CW'(1);
        end else begin
          hi <= mid;
        end
      end
      if (dp_cmd.idx_dec) begin
        idx <= idx_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.finish) begin
      unique case (dp_cmd.fin_kind)
        skl_pkg::FIN_OVF: begin
          found        <= 1'b0;
          result_value <= '0;
          overflow     <= 1'b1;
        end
        skl_pkg::FIN_CHECK: begin
          found        <= key_hit;
          result_value <= key_hit ? rd_val : '0;
          overflow     <= 1'b0;
        end
        default: begin
          found        <= 1'b0;
          result_value <= '0;
          overflow     <= 1'b0;
        end
      endcase
    end
  end

  assign dp_stat.full        = (count == CW'(TABLE_DEPTH));
  assign dp_stat.search_done = (lo >= hi);
  assign dp_stat.shift_done  = (idx == lo);
  assign dp_stat.lo_valid    = (lo < count);

endmodule

`default_nettype wire

/* sv/skl_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module skl_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [skl_pkg::CMD_W-1:0] cmd,
  input  wire skl_pkg::dp_stat_t         dp_stat,
  output skl_pkg::dp_cmd_t               dp_cmd,
  output logic                           busy,
  output logic                           done
);

  typedef enum logic [2:0] {
    IDLE,
    SEARCH,
    COMPARE,
    CHECK,
    SHIFT_RD,
    SHIFT_WR
  } state_t;

  state_t state;
  state_t state_next;
  logic   is_load;
  logic   accept;

  assign accept = start & ~busy;

  always_comb begin
    state_next        = state;
    dp_cmd            = '0;
    dp_cmd.fin_kind   = skl_pkg::FIN_ZERO;
    dp_cmd.past_equal = is_load;
    unique case (state)
      IDLE: begin
        if (accept) begin
          dp_cmd.capture    = 1'b1;
          dp_cmd.past_equal = (cmd == skl_pkg::CMD_LOAD);
          unique case (cmd)
            skl_pkg::CMD_LOAD: begin
              if (dp_stat.full) begin
                dp_cmd.finish   = 1'b1;
                dp_cmd.fin_kind = skl_pkg::FIN_OVF;
              end else begin
                dp_cmd.srch_init = 1'b1;
                state_next       = SEARCH;
              end
            end
            skl_pkg::CMD_LOOKUP: begin
              dp_cmd.srch_init = 1'b1;
              state_next       = SEARCH;
            end
            skl_pkg::CMD_CLEAR: begin
              dp_cmd.count_clr = 1'b1;
              dp_cmd.finish    = 1'b1;
            end
            default: begin
              dp_cmd.finish = 1'b1;
            end
          endcase
        end
      end
      SEARCH: begin
        if (!dp_stat.search_done) begin
          dp_cmd.rd_mid = 1'b1;
          state_next    = COMPARE;
        end else if (is_load) begin
          state_next = SHIFT_RD;
        end else if (dp_stat.lo_valid) begin
          dp_cmd.rd_lo = 1'b1;
          state_next   = CHECK;
        end else begin
          dp_cmd.finish = 1'b1;
          state_next    = IDLE;
        end
      end
      COMPARE: begin
        dp_cmd.srch_step = 1'b1;
        state_next       = SEARCH;
      end
      CHECK: begin
        dp_cmd.finish   = 1'b1;
        dp_cmd.fin_kind = skl_pkg::FIN_CHECK;
        state_next      = IDLE;
      end
      SHIFT_RD: begin
        // move entries above the insert point up one place, top first
        if (dp_stat.shift_done) begin
          dp_cmd.wr_new = 1'b1;
          dp_cmd.finish = 1'b1;
          state_next    = IDLE;
        end else begin
          dp_cmd.rd_shift = 1'b1;
          state_next      = SHIFT_WR;
        end
      end
      SHIFT_WR: begin
        dp_cmd.wr_shift = 1'b1;
        dp_cmd.idx_dec  = 1'b1;
        state_next      = SHIFT_RD;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      busy    <= 1'b0;
      done    <= 1'b0;
      is_load <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != IDLE);
      done  <= dp_cmd.finish;
      if (accept) begin
        is_load <= (cmd == skl_pkg::CMD_LOAD);
      end
    end
  end

endmodule

`default_nettype wire

/* sv/skl_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module skl_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic [skl_pkg::CMD_W-1:0] cmd,
  input wire logic                      done,
  input wire logic                      found,
  input wire logic [skl_pkg::VAL_W-1:0] result_value,
  input wire logic                      overflow
);

  // clear never waits
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && (cmd == skl_pkg::CMD_CLEAR) |=> done && !busy && !found && !overflow)
    else $error("clear transaction did not finish in one cycle");

  // busy only rises after a transaction is taken
  assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start) && !$past(busy))
    else $error("busy rose without an accepted transaction");

  // a miss reports zero
  assert property (@(posedge clk) disable iff (rst)
    done && !found |-> (result_value == '0))
    else $error("result_value nonzero without a match");

  assert property (@(posedge clk) disable iff (rst)
    done |-> !(found && overflow))
    else $error("found and overflow both set");

  assert property (@(posedge clk)
    rst |=> !busy && !done)
    else $error("busy or done set right after reset");

endmodule

bind sorted_key_table_lookup skl_checker u_skl_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .cmd          (cmd),
  .done         (done),
  .found        (found),
  .result_value (result_value),
  .overflow     (overflow)
);

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int CMD_W = skl_pkg::CMD_W;
  localparam int KEY_W = skl_pkg::KEY_W;
  localparam int VAL_W = skl_pkg::VAL_W;
  localparam int DEPTH = skl_pkg::TABLE_DEPTH_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // slowest load is a full search plus a shift of every stored entry; the limit is many times the worst run
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TAIL_CYCLES = 2 * DEPTH + 16;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic [KEY_W-1:0] key;
    logic             found;
    logic [VAL_W-1:0] value;
    logic             overflow;
  } answer_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [CMD_W-1:0] cmd = skl_pkg::CMD_LOAD;
  logic [KEY_W-1:0] key = '0;
  logic [VAL_W-1:0] value = '0;
  logic             busy;
  logic             done;
  logic             found;
  logic [VAL_W-1:0] result_value;
  logic             overflow;

  sorted_key_table_lookup #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .key(key),
    .value(value),
    .done(done),
    .found(found),
    .result_value(result_value),
    .overflow(overflow)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // shadow copy of the sorted table
  logic [KEY_W-1:0] shadow_keys [DEPTH];
  logic [VAL_W-1:0] shadow_vals [DEPTH];
  int               shadow_count = 0;

  answer_t pending_answers [$];
  int      errors = 0;
  int      cycles = 0;
  int      send_idle_pct = 0;
  int      n_loads = 0;
  int      n_hits = 0;
  int      n_misses = 0;
  int      n_overflows = 0;
  int      n_clears = 0;

  function automatic answer_t sorted_table_step(input logic [CMD_W-1:0] c,
                                                input logic [KEY_W-1:0] k,
                                                input logic [VAL_W-1:0] v);
    answer_t a;
    int      pos;
    a = '0;
    a.op = c;
    a.key = k;
    case (c)
      skl_pkg::CMD_LOAD: begin
        if (shadow_count >= DEPTH) begin
          a.overflow = 1'b1;
          n_overflows++;
        end else begin
          // new entry goes after every entry with an equal key
          pos = 0;
          while (pos < shadow_count && shadow_keys[pos] <= k) pos++;
          for (int i = shadow_count; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_vals[i] = shadow_vals[i-1];
          end
          shadow_keys[pos] = k;
          shadow_vals[pos] = v;
          shadow_count++;
          n_loads++;
        end
      end
      skl_pkg::CMD_LOOKUP: begin
        // first of the equal keys answers
        pos = 0;
        while (pos < shadow_count && shadow_keys[pos] < k) pos++;
        if (pos < shadow_count && shadow_keys[pos] == k) begin
          a.found = 1'b1;
          a.value = shadow_vals[pos];
          n_hits++;
        end else begin
          n_misses++;
        end
      end
      skl_pkg::CMD_CLEAR: begin
        shadow_count = 0;
        n_clears++;
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    int r;
    r = $urandom_range(9);
    if (r < 5) return KEY_W'($urandom_range(40));
    if (r < 7) begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return '1;
        2:       return {1'b0, {(KEY_W-1){1'b1}}};
        default: return {1'b1, {(KEY_W-1){1'b0}}};
      endcase
    end
    return $urandom;
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                           input logic [VAL_W-1:0] v);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    key <= k;
    value <= v;
    do @(posedge clk); while (busy);
    pending_answers.insert(pending_answers.size(), sorted_table_step(c, k, v));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic test_basics();
    send_idle_pct = 10;
    send_item(skl_pkg::CMD_LOOKUP, '0, $urandom);
    send_item(skl_pkg::CMD_LOOKUP, '1, $urandom);
    send_item(skl_pkg::CMD_LOAD, '0, '1);
    send_item(skl_pkg::CMD_LOAD, '1, '0);
    send_item(skl_pkg::CMD_LOAD, 32'h8000_0000, 32'h1234_5678);
    send_item(skl_pkg::CMD_LOAD, 32'h8000_0000, 32'hAAAA_5555);
    send_item(skl_pkg::CMD_LOAD, '0, 32'h0000_0001);
    send_item(skl_pkg::CMD_LOOKUP, '0, $urandom);
    send_item(skl_pkg::CMD_LOOKUP, '1, $urandom);
    send_item(skl_pkg::CMD_LOOKUP, 32'h8000_0000, $urandom);
    send_item(skl_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, $urandom);
    send_item(skl_pkg::CMD_LOOKUP, 32'h0000_0001, $urandom);
    send_item(CMD_UNUSED, '0, '1);
    send_item(skl_pkg::CMD_LOOKUP, '0, $urandom);
    send_item(skl_pkg::CMD_CLEAR, '1, '1);
    send_item(skl_pkg::CMD_LOOKUP, '0, $urandom);
    send_item(skl_pkg::CMD_LOAD, 32'd5, 32'h5555_AAAA);
    send_item(skl_pkg::CMD_LOOKUP, 32'd5, '0);
    send_item(skl_pkg::CMD_LOAD, 32'd3, 32'hDEAD_BEEF);
    send_item(skl_pkg::CMD_LOOKUP, 32'd3, '0);
    send_item(skl_pkg::CMD_LOOKUP, 32'd4, '0);
    send_item(skl_pkg::CMD_CLEAR, '0, '0);
  endtask

  task automatic test_table_full();
    logic [KEY_W-1:0] base;
    send_idle_pct = 0;
    base = $urandom_range(32'hFFFF_0000, 32'h0001_0000);
    send_item(skl_pkg::CMD_CLEAR, $urandom, $urandom);
    // descending keys land at the front, so every load shifts the whole table
    for (int i = 0; i < DEPTH; i++) send_item(skl_pkg::CMD_LOAD, base - 3 * i, $urandom);
    send_item(skl_pkg::CMD_LOAD, base, $urandom);
    send_item(skl_pkg::CMD_LOAD, '1, $urandom);
    send_item(skl_pkg::CMD_LOAD, '0, $urandom);
    send_item(skl_pkg::CMD_LOOKUP, base, $urandom);
    send_item(skl_pkg::CMD_LOOKUP, base - 3 * (DEPTH - 1), $urandom);
    send_item(skl_pkg::CMD_LOOKUP, base - 1, $urandom);
    send_item(skl_pkg::CMD_LOOKUP, '1, $urandom);
    send_item(CMD_UNUSED, base, $urandom);
    repeat (8) begin
      send_item(skl_pkg::CMD_LOOKUP, shadow_keys[$urandom_range(DEPTH - 1)], $urandom);
    end
    send_item(skl_pkg::CMD_CLEAR, $urandom, $urandom);
    send_item(skl_pkg::CMD_LOOKUP, base, $urandom);
  endtask

  // episodes of loads and lookups, each opened by a clear
  task automatic test_random(input int idle_pct, input int n_items);
    int               counted;
    int               episode_left;
    int               load_pct;
    int               r;
    logic [CMD_W-1:0] c;
    logic [KEY_W-1:0] k;
    send_idle_pct = idle_pct;
    counted = 0;
    episode_left = 0;
    load_pct = 50;
    while (counted < n_items) begin
      if (episode_left == 0) begin
        send_item(skl_pkg::CMD_CLEAR, $urandom, $urandom);
        counted++;
        episode_left = $urandom_range(130, 8);
        load_pct = $urandom_range(80, 25);
      end
      r = $urandom_range(99);
      if (r < 2) c = CMD_UNUSED;
      else if (r < 3) c = skl_pkg::CMD_CLEAR;
      else if ($urandom_range(99) < load_pct) c = skl_pkg::CMD_LOAD;
      else c = skl_pkg::CMD_LOOKUP;
      k = random_key();
      if (c == skl_pkg::CMD_LOOKUP && shadow_count > 0 && $urandom_range(1)) begin
        k = shadow_keys[$urandom_range(shadow_count - 1)];
        // near misses around stored keys
        if ($urandom_range(3) == 0) k = $urandom_range(1) ? k + 1 : k - 1;
      end
      send_item(c, k, $urandom);
      if (c != CMD_UNUSED) counted++;
      episode_left--;
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: no finish after %0d cycles", $time, cycles);
      $display("[sorted_key_table_lookup] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: result with no transaction pending: found %0b value %h overflow %0b",
                 $time, found, result_value, overflow);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (found !== want.found) begin
          $display("%0t: cmd %0d key %h found expected %0b actual %0b",
                   $time, want.op, want.key, want.found, found);
          errors++;
        end
        if (result_value !== want.value) begin
          $display("%0t: cmd %0d key %h result_value expected %h actual %h",
                   $time, want.op, want.key, want.value, result_value);
          errors++;
        end
        if (overflow !== want.overflow) begin
          $display("%0t: cmd %0d key %h overflow expected %0b actual %0b",
                   $time, want.op, want.key, want.overflow, overflow);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_basics();
    wait_drained();
    test_table_full();
    wait_drained();
    test_random(10, 410);
    wait_drained();
    test_random(48, 410);
    test_random(0, 410);
    wait_drained();
    // watch for stray results after the last transaction
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d inserts, %0d lookup hits, %0d lookup misses,", n_loads, n_hits,
             n_misses);
    $display("%0d dropped loads on a full table and %0d clears in %0d cycles", n_overflows,
             n_clears, cycles);
    if (errors == 0) begin
      $display("[sorted_key_table_lookup] OK");
    end else begin
      $display("[sorted_key_table_lookup] ERROR");
    end
    $finish;
  end

endmodule
